### design/gwms_pkg.sv
`timescale 1ns / 1ps
// package: shared constants and types for the window mean and steadiness block
package gwms_pkg;
	localparam int WINDOW_MAX = 64;
	localparam int AW = $clog2(WINDOW_MAX);
	localparam int CW = $clog2(WINDOW_MAX + 1);
	localparam int LAT_W = 31;
	localparam int LON_W = 32;
	localparam int ALT_W = 25;
	localparam int TOL_W = 40;
	localparam int CFG_W = 40;
	localparam int SUM_W = 40;
	localparam int RAM_W = LAT_W + LON_W + ALT_W;
	localparam int WSZ_W = 7;
	localparam int REG_WINDOW_SIZE = 0;
	localparam int REG_STEADY_TOL = 1;
	localparam logic [WSZ_W-1:0] WSZ_RESET = WSZ_W'(10);
	localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(10000);
endpackage

### design/gwms_ram.sv
`timescale 1ns / 1ps
// generic single-port-write, single-port-read ram with registered read
module gwms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

### design/gwms_div.sv
`timescale 1ns / 1ps
// restoring divider: signed sum over unsigned count, truncated toward zero
module gwms_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [gwms_pkg::SUM_W-1:0] dividend,
	input  logic [gwms_pkg::CW-1:0]   divisor,
	output logic                      done,
	output logic signed [gwms_pkg::SUM_W-1:0] quotient
);
	import gwms_pkg::*;
	logic [SUM_W-1:0] num_q;
	logic [CW:0]      rem_q;
	logic [CW-1:0]    den_q;
	logic             neg_q;
	logic             busy_q;
	logic [$clog2(SUM_W+1)-1:0] cnt_q;
	logic [CW:0]      trial;
	logic [CW:0]      sub;

	assign trial = {rem_q[CW-1:0], num_q[SUM_W-1]};
	assign sub = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= ($clog2(SUM_W+1))'(SUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == ($clog2(SUM_W+1))'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SUM_W-1];
			num_q <= dividend[SUM_W-1] ? SUM_W'(-dividend) : dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			if (!sub[CW]) begin
				rem_q <= sub;
				num_q <= {num_q[SUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				num_q <= {num_q[SUM_W-2:0], 1'b0};
			end
		end
	end

	assign quotient = neg_q ? -$signed(num_q) : $signed(num_q);
endmodule

### design/gps_window_mean_steadiness.sv
`timescale 1ns / 1ps
// top level: gps fix ring, window means and steadiness flag
//
//  channel | handshake            | payload
//  fix in  | in_valid / in_ready  | fix_lat fix_lon fix_alt restart
//  result  | out_valid / out_ready| mean_lat mean_lon mean_alt window_full steady
//  config  | cfg_we               | cfg_index cfg_data
//
// one word at a time: write on accept, sum pass over count entries, three serial
// divides, deviation pass, then a load of the output register. the shared divider
// serves all three axes and the one read port of the ring ram serves both passes.
// a finished word sits in the output register; the next fix is taken once the result
// has been handed over, so an output stall holds off the next fix.
// reset clears fill count, write slot and control and sets config to its reset values; the ring is not cleared.
module gps_window_mean_steadiness (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [gwms_pkg::LAT_W-1:0] fix_lat,
	input  logic signed [gwms_pkg::LON_W-1:0] fix_lon,
	input  logic signed [gwms_pkg::ALT_W-1:0] fix_alt,
	input  logic restart,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [gwms_pkg::LAT_W-1:0] mean_lat,
	output logic signed [gwms_pkg::LON_W-1:0] mean_lon,
	output logic signed [gwms_pkg::ALT_W-1:0] mean_alt,
	output logic window_full,
	output logic steady,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [gwms_pkg::CFG_W-1:0] cfg_data
);
	import gwms_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SUM  = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_DEV  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]       state_q;
	logic [WSZ_W-1:0] wsz_cfg_q;
	logic [TOL_W-1:0] tol_q;
	logic [CW-1:0]    fill_q;
	logic [AW-1:0]    wslot_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    wsz_eff;
	logic [CW-1:0]    issue_q;   // reads issued in the current pass
	logic [CW-1:0]    recv_q;    // reads returned
	logic             rd_s1;
	logic [AW-1:0]    rptr_q;
	logic signed [SUM_W-1:0] slat_q, slon_q, salt_q;
	logic [1:0]       axis_q;
	logic             div_start_q;
	logic             div_done;
	logic signed [SUM_W-1:0] div_in, div_q;
	logic signed [LAT_W-1:0] mlat_q;
	logic signed [LON_W-1:0] mlon_q;
	logic signed [ALT_W-1:0] malt_q;
	logic [64:0]      dlat_q, dlon_q;
	logic [63:0]      sqlat_s2, sqlon_s2;
	logic             sq_v_s2;
	logic [TOL_W+CW-1:0] limit_q;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr, ram_raddr;
	logic [RAM_W-1:0] ram_wdata, ram_rdata;
	logic signed [LAT_W-1:0] r_lat;
	logic signed [LON_W-1:0] r_lon;
	logic signed [ALT_W-1:0] r_alt;
	logic signed [LON_W:0]   dev_lat, dev_lon;
	logic [LON_W-1:0]        abs_lat, abs_lon;
	logic [CW-1:0]           fill_next;
	logic [AW-1:0]           slot_base;

	// clamp the window size to 1..WINDOW_MAX
	always_comb begin
		if (wsz_cfg_q == '0) wsz_eff = CW'(1);
		else if (32'(wsz_cfg_q) > WINDOW_MAX) wsz_eff = CW'(WINDOW_MAX);
		else wsz_eff = CW'(wsz_cfg_q);
	end

	assign in_ready = (state_q == ST_IDLE);
	assign slot_base = restart ? '0 : wslot_q;
	always_comb begin
		fill_next = (restart ? CW'(0) : fill_q) + CW'(1);
		if (fill_next > wsz_eff) fill_next = wsz_eff;
	end

	assign ram_we = in_valid && in_ready;
	assign ram_waddr = slot_base;
	assign ram_wdata = {fix_lat, fix_lon, fix_alt};
	assign ram_raddr = rptr_q;

	gwms_ram #(.WIDTH(RAM_W), .DEPTH(WINDOW_MAX)) u_ring (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	assign r_lat = ram_rdata[RAM_W-1 -: LAT_W];
	assign r_lon = ram_rdata[ALT_W +: LON_W];
	assign r_alt = ram_rdata[ALT_W-1:0];

	always_comb begin
		case (axis_q)
			2'd0: div_in = slat_q;
			2'd1: div_in = slon_q;
			default: div_in = salt_q;
		endcase
	end

	gwms_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start_q), .dividend(div_in),
		.divisor(count_q), .done(div_done), .quotient(div_q)
	);

	// deviations fit 33 bits, squares fit 64
	assign dev_lat = (LON_W+1)'(r_lat) - (LON_W+1)'(mlat_q);
	assign dev_lon = (LON_W+1)'(r_lon) - (LON_W+1)'(mlon_q);
	assign abs_lat = LON_W'(dev_lat[LON_W] ? -dev_lat : dev_lat);
	assign abs_lon = LON_W'(dev_lon[LON_W] ? -dev_lon : dev_lon);

	always_ff @(posedge clk) begin
		sqlat_s2 <= 64'(abs_lat) * 64'(abs_lat);
		sqlon_s2 <= 64'(abs_lon) * 64'(abs_lon);
		limit_q  <= tol_q * (TOL_W+CW)'(count_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wsz_cfg_q <= WSZ_RESET;
			tol_q <= TOL_RESET;
			fill_q <= '0;
			wslot_q <= '0;
			out_valid <= 1'b0;
			rd_s1 <= 1'b0;
			sq_v_s2 <= 1'b0;
			div_start_q <= 1'b0;
			issue_q <= '0;
			recv_q <= '0;
			axis_q <= '0;
		end else begin
			div_start_q <= 1'b0;
			rd_s1 <= 1'b0;
			sq_v_s2 <= 1'b0;
			if (cfg_we) begin
				if (cfg_index == 1'(REG_WINDOW_SIZE)) wsz_cfg_q <= cfg_data[WSZ_W-1:0];
				else tol_q <= cfg_data[TOL_W-1:0];
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						fill_q <= fill_next;
						count_q <= fill_next;
						wslot_q <= slot_base + 1'b1;
						rptr_q <= slot_base;
						issue_q <= '0;
						recv_q <= '0;
						slat_q <= '0;
						slon_q <= '0;
						salt_q <= '0;
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					// read newest first, walking backward through the ring
					if (issue_q != count_q) begin
						rd_s1 <= 1'b1;
						issue_q <= issue_q + 1'b1;
						rptr_q <= rptr_q - 1'b1;
					end
					if (rd_s1) begin
						slat_q <= slat_q + SUM_W'(r_lat);
						slon_q <= slon_q + SUM_W'(r_lon);
						salt_q <= salt_q + SUM_W'(r_alt);
						recv_q <= recv_q + 1'b1;
						if (recv_q + 1'b1 == count_q) begin
							state_q <= ST_DIV;
							axis_q <= 2'd0;
							div_start_q <= 1'b1;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						case (axis_q)
							2'd0: mlat_q <= LAT_W'(div_q);
							2'd1: mlon_q <= LON_W'(div_q);
							default: malt_q <= ALT_W'(div_q);
						endcase
						if (axis_q == 2'd2) begin
							state_q <= ST_DEV;
							rptr_q <= wslot_q - 1'b1;
							issue_q <= '0;
							recv_q <= '0;
							dlat_q <= '0;
							dlon_q <= '0;
						end else begin
							axis_q <= axis_q + 1'b1;
							div_start_q <= 1'b1;
						end
					end
				end
				ST_DEV: begin
					if (issue_q != count_q) begin
						rd_s1 <= 1'b1;
						issue_q <= issue_q + 1'b1;
						rptr_q <= rptr_q - 1'b1;
					end
					sq_v_s2 <= rd_s1;
					if (sq_v_s2) begin
						// 65-bit sum; top bit marks saturation
						dlat_q <= dlat_q[64] ? dlat_q : dlat_q + 65'(sqlat_s2);
						dlon_q <= dlon_q[64] ? dlon_q : dlon_q + 65'(sqlon_s2);
						recv_q <= recv_q + 1'b1;
						if (recv_q + 1'b1 == count_q) state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_valid) begin
						out_valid <= 1'b1;
						mean_lat <= mlat_q;
						mean_lon <= mlon_q;
						mean_alt <= malt_q;
						window_full <= (count_q >= wsz_eff);
						steady <= (dlat_q <= 65'(limit_q)) && (dlon_q <= 65'(limit_q));
					end else if (out_ready) begin
						out_valid <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// a fix is never taken while a result is still pending
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("fix accepted with result pending");
	// the fill count never exceeds the window maximum
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) <= WINDOW_MAX) else $error("fill count overflow");
	// divider start only ever pulses in the divide state
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start_q |-> state_q == ST_DIV) else $error("stray divider start");
`endif
endmodule
